@@ hdl/vector_magnitude_level_tracker_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the vector magnitude level tracker
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef VECTOR_MAGNITUDE_LEVEL_TRACKER_CORE_ASSERT_SVH
`define VECTOR_MAGNITUDE_LEVEL_TRACKER_CORE_ASSERT_SVH

// condition holds at every edge
`define VMLT_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define VMLT_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the cycle after the antecedent
`define VMLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/vmlt_pkg.sv @@
// ----------------------------------------------------------------------------
// Vector magnitude level tracker package
// Register indexes, operation and mode codes, Q1.16 helpers.
// ----------------------------------------------------------------------------
package vmlt_pkg;

	localparam int unsigned SAMPLE_COUNT_MAX_DEF = 1023;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_LEVEL_LOW      = 3'd0;
	localparam logic [2:0] REG_LEVEL_HIGH     = 3'd1;
	localparam logic [2:0] REG_MEAN_SMOOTHING = 3'd2;
	localparam logic [2:0] REG_PEAK_SMOOTHING = 3'd3;
	localparam logic [2:0] REG_DECAY_FACTOR   = 3'd4;
	localparam logic [2:0] REG_COMPONENT_MODE = 3'd5;

	// register reset values
	localparam logic [16:0] LEVEL_HIGH_RST   = 17'd65536;
	localparam logic [16:0] DECAY_FACTOR_RST = 17'd62259;

	// component selection modes
	localparam logic [1:0] MODE_XY   = 2'd0;
	localparam logic [1:0] MODE_ZW   = 2'd1;
	localparam logic [1:0] MODE_XYZ  = 2'd2;
	localparam logic [1:0] MODE_XYZW = 2'd3;

	// operation codes carried on tuser
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	function automatic logic [16:0] clamp_q16(input logic [16:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

	function automatic logic [15:0] abs16(input logic signed [15:0] v);
		logic [15:0] u;
		u = v;
		return v[15] ? (~u + 16'd1) : u;
	endfunction

endpackage

@@ hdl/vector_magnitude_level_tracker_core.sv @@
// A vector sample runs four squares on the shared 17x17 multiplier, 17 square-root digit steps
// and one accumulate before the block is idle again; a bad size is dropped on acceptance.
// A frame tick with samples runs CNT_W+16 divider steps for the mean, divider steps for each
// level not set directly, two smoothing passes and one emit; an empty frame decays first; one divider.
// Throughput: one item at a time; s_tready is high only when the sequencer is idle.
// Reset: arst_n clears state, accumulators, smoothed levels and sets registers to their defaults.
// ----------------------------------------------------------------------------
// Vector magnitude level tracker core
// Accumulates vector lengths per frame and emits smoothed Q1.16 mean and peak
// levels on each frame tick, using one multiplier, one root unit and one divider.
// ----------------------------------------------------------------------------
`include "vector_magnitude_level_tracker_core_assert.svh"

module vector_magnitude_level_tracker_core #(
	parameter int unsigned SAMPLE_COUNT_MAX = vmlt_pkg::SAMPLE_COUNT_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // vector_size[2:0], comp_x, comp_y, comp_z, comp_w, zero pad
	input  logic        s_tuser,  // operation
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // mean_level, peak_level, raw_mean, raw_peak, samples_seen, pad
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned CNT_W = $clog2(SAMPLE_COUNT_MAX + 1);
	localparam int unsigned SUM_W = CNT_W + 16;
	localparam int unsigned DV_W  = (CNT_W > 17) ? CNT_W : 17;
	localparam int unsigned DK_W  = $clog2(SUM_W + 1);
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(SAMPLE_COUNT_MAX);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MAC, ST_ROOT, ST_ACC, ST_NORM, ST_DIV, ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		JOB_SQR, JOB_DEC_MEAN, JOB_DEC_PEAK, JOB_SM_MEAN, JOB_SM_PEAK
	} job_t;

	// configuration registers
	logic [16:0] level_low_q, level_high_q, mean_smoothing_q, peak_smoothing_q;
	logic [16:0] decay_factor_q;
	logic [1:0]  component_mode_q;

	// sequencer
	state_t state_q;
	job_t   job_q;
	logic [2:0] mac_k_q, mac_n_q;
	logic       norm_sel_q, div_norm_q;

	// datapath
	logic [15:0] sq_op_q [4];
	logic [33:0] prod_q;
	logic [34:0] acc_q;
	logic [32:0] n_q, bit_q;
	logic [33:0] res_q;
	logic [DV_W-1:0]  rem_q, dvs_q;
	logic [SUM_W-1:0] dvd_q, quo_q;
	logic [DK_W-1:0]  div_k_q;

	// frame accumulators and smoothed state
	logic [SUM_W-1:0] sum_q;
	logic [16:0]      peak_q;
	logic [CNT_W-1:0] cnt_q;
	logic [16:0] mean_st_q, peak_st_q;
	logic [16:0] raw_mean_q, raw_peak_q, lvl_mean_q, lvl_peak_q;
	logic [9:0]  seen_q;

	// output register
	logic        m_valid_q;
	logic [16:0] o_mean_q, o_peak_q, o_raw_mean_q, o_raw_peak_q;
	logic [9:0]  o_seen_q;
	logic        emit_fire;

	// load the output register once it is empty or draining
	assign emit_fire = (state_q == ST_EMIT) && (!m_valid_q || m_tready);

	// input decode
	logic [2:0]         in_size;
	logic signed [15:0] in_comp [4];
	logic [3:0]         use_mask;
	logic               size_ok;
	logic               in_accept;
	logic [CNT_W+9:0]   cnt_ext;

	assign in_size    = s_tdata[2:0];
	assign in_comp[0] = s_tdata[18:3];
	assign in_comp[1] = s_tdata[34:19];
	assign in_comp[2] = s_tdata[50:35];
	assign in_comp[3] = s_tdata[66:51];
	assign s_tready   = (state_q == ST_IDLE);
	assign in_accept  = s_tvalid && s_tready;
	assign cnt_ext    = {10'd0, cnt_q};

	always_comb begin
		size_ok  = 1'b1;
		use_mask = 4'b0011;
		unique case (in_size)
			3'd2: use_mask = 4'b0011;
			3'd3: use_mask = (component_mode_q == vmlt_pkg::MODE_XYZ) ? 4'b0111 : 4'b0011;
			3'd4: begin
				if (component_mode_q == vmlt_pkg::MODE_XY)
					use_mask = 4'b0011;
				else if (component_mode_q == vmlt_pkg::MODE_XYZW)
					use_mask = 4'b1111;
				else
					use_mask = 4'b1100;
			end
			default: size_ok = 1'b0;
		endcase
	end

	// shared multiplier operand select
	logic [16:0] mul_a, mul_b, s_mean, s_peak, d_clamp;
	logic [33:0] mul_p;
	logic [34:0] mac_sum;

	assign s_mean  = vmlt_pkg::clamp_q16(mean_smoothing_q);
	assign s_peak  = vmlt_pkg::clamp_q16(peak_smoothing_q);
	assign d_clamp = vmlt_pkg::clamp_q16(decay_factor_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (job_q)
			JOB_SQR: begin
				mul_a = {1'b0, sq_op_q[mac_k_q[1:0]]};
				mul_b = {1'b0, sq_op_q[mac_k_q[1:0]]};
			end
			JOB_DEC_MEAN: begin
				mul_a = mean_st_q;
				mul_b = d_clamp;
			end
			JOB_DEC_PEAK: begin
				mul_a = peak_st_q;
				mul_b = d_clamp;
			end
			JOB_SM_MEAN: begin
				mul_a = (mac_k_q == 3'd0) ? mean_st_q : lvl_mean_q;
				mul_b = (mac_k_q == 3'd0) ? s_mean : (vmlt_pkg::ONE_Q16 - s_mean);
			end
			JOB_SM_PEAK: begin
				mul_a = (mac_k_q == 3'd0) ? peak_st_q : lvl_peak_q;
				mul_b = (mac_k_q == 3'd0) ? s_peak : (vmlt_pkg::ONE_Q16 - s_peak);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign mac_sum = acc_q + {1'b0, prod_q};

	// square root digit step
	logic [33:0] root_t, res_take;
	logic        root_ge;
	logic [32:0] n_next;

	assign root_t   = res_q + {1'b0, bit_q};
	assign root_ge  = ({1'b0, n_q} >= root_t);
	assign n_next   = n_q - root_t[32:0];
	assign res_take = (res_q >> 1) + {1'b0, bit_q};

	// restoring divider step
	logic [DV_W:0]    div_shift;
	logic             div_ge;
	logic [DV_W-1:0]  rem_next;
	logic [SUM_W-1:0] quo_next;

	assign div_shift = {rem_q, dvd_q[SUM_W-1]};
	assign div_ge    = (div_shift >= {1'b0, dvs_q});
	assign rem_next  = div_ge ? DV_W'(div_shift - {1'b0, dvs_q}) : div_shift[DV_W-1:0];
	assign quo_next  = {quo_q[SUM_W-2:0], div_ge};

	// normalisation: edge cases direct, the rest through the divider
	logic [16:0] norm_v, norm_val;
	logic        norm_direct;

	assign norm_v = norm_sel_q ? raw_peak_q : raw_mean_q;

	always_comb begin
		norm_direct = 1'b1;
		norm_val    = '0;
		priority if (level_high_q <= level_low_q)
			norm_val = (norm_v > level_low_q) ? vmlt_pkg::ONE_Q16 : 17'd0;
		else if (norm_v <= level_low_q)
			norm_val = '0;
		else if (norm_v >= level_high_q)
			norm_val = vmlt_pkg::ONE_Q16;
		else
			norm_direct = 1'b0;
	end

	// configuration port
	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_low_q      <= '0;
			level_high_q     <= vmlt_pkg::LEVEL_HIGH_RST;
			mean_smoothing_q <= '0;
			peak_smoothing_q <= '0;
			decay_factor_q   <= vmlt_pkg::DECAY_FACTOR_RST;
			component_mode_q <= vmlt_pkg::MODE_ZW;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				vmlt_pkg::REG_LEVEL_LOW:      level_low_q      <= pwdata[16:0];
				vmlt_pkg::REG_LEVEL_HIGH:     level_high_q     <= pwdata[16:0];
				vmlt_pkg::REG_MEAN_SMOOTHING: mean_smoothing_q <= pwdata[16:0];
				vmlt_pkg::REG_PEAK_SMOOTHING: peak_smoothing_q <= pwdata[16:0];
				vmlt_pkg::REG_DECAY_FACTOR:   decay_factor_q   <= pwdata[16:0];
				vmlt_pkg::REG_COMPONENT_MODE: component_mode_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			vmlt_pkg::REG_LEVEL_LOW:      prdata = {15'd0, level_low_q};
			vmlt_pkg::REG_LEVEL_HIGH:     prdata = {15'd0, level_high_q};
			vmlt_pkg::REG_MEAN_SMOOTHING: prdata = {15'd0, mean_smoothing_q};
			vmlt_pkg::REG_PEAK_SMOOTHING: prdata = {15'd0, peak_smoothing_q};
			vmlt_pkg::REG_DECAY_FACTOR:   prdata = {15'd0, decay_factor_q};
			vmlt_pkg::REG_COMPONENT_MODE: prdata = {30'd0, component_mode_q};
			default:                      prdata = '0;
		endcase
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			job_q      <= JOB_SQR;
			mac_k_q    <= '0;
			mac_n_q    <= '0;
			norm_sel_q <= 1'b0;
			div_norm_q <= 1'b0;
			for (int i = 0; i < 4; i++)
				sq_op_q[i] <= '0;
			prod_q     <= '0;
			acc_q      <= '0;
			n_q        <= '0;
			bit_q      <= '0;
			res_q      <= '0;
			rem_q      <= '0;
			dvs_q      <= '0;
			dvd_q      <= '0;
			quo_q      <= '0;
			div_k_q    <= '0;
			sum_q      <= '0;
			peak_q     <= '0;
			cnt_q      <= '0;
			mean_st_q  <= '0;
			peak_st_q  <= '0;
			raw_mean_q <= '0;
			raw_peak_q <= '0;
			lvl_mean_q <= '0;
			lvl_peak_q <= '0;
			seen_q     <= '0;
			m_valid_q  <= 1'b0;
			o_mean_q     <= '0;
			o_peak_q     <= '0;
			o_raw_mean_q <= '0;
			o_raw_peak_q <= '0;
			o_seen_q     <= '0;
		end else begin
			if (emit_fire)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (s_tuser == vmlt_pkg::OP_TICK) begin
							seen_q <= cnt_ext[9:0];
							sum_q  <= '0;
							peak_q <= '0;
							cnt_q  <= '0;
							if (cnt_q != '0) begin
								raw_peak_q <= peak_q;
								rem_q      <= '0;
								dvd_q      <= sum_q;
								dvs_q      <= DV_W'(cnt_q);
								quo_q      <= '0;
								div_k_q    <= DK_W'(SUM_W);
								div_norm_q <= 1'b0;
								state_q    <= ST_DIV;
							end else begin
								// empty frame: decay both states first
								raw_mean_q <= '0;
								raw_peak_q <= '0;
								job_q      <= JOB_DEC_MEAN;
								mac_k_q    <= '0;
								mac_n_q    <= 3'd1;
								acc_q      <= '0;
								state_q    <= ST_MAC;
							end
						end else if (size_ok) begin
							for (int i = 0; i < 4; i++)
								sq_op_q[i] <= use_mask[i] ? vmlt_pkg::abs16(in_comp[i]) : 16'd0;
							job_q   <= JOB_SQR;
							mac_k_q <= '0;
							mac_n_q <= 3'd4;
							acc_q   <= '0;
							state_q <= ST_MAC;
						end
					end
				end

				ST_MAC: begin
					if (mac_k_q != mac_n_q) begin
						prod_q  <= mul_p;
						mac_k_q <= mac_k_q + 3'd1;
					end
					if ((mac_k_q != 3'd0) && (mac_k_q != mac_n_q))
						acc_q <= mac_sum;
					if (mac_k_q == mac_n_q) begin
						unique case (job_q)
							JOB_SQR: begin
								n_q     <= mac_sum[32:0];
								res_q   <= '0;
								bit_q   <= 33'h1_0000_0000;
								state_q <= ST_ROOT;
							end
							JOB_DEC_MEAN: begin
								mean_st_q <= mac_sum[32:16];
								job_q     <= JOB_DEC_PEAK;
								mac_k_q   <= '0;
								acc_q     <= '0;
							end
							JOB_DEC_PEAK: begin
								peak_st_q  <= mac_sum[32:16];
								norm_sel_q <= 1'b0;
								state_q    <= ST_NORM;
							end
							JOB_SM_MEAN: begin
								mean_st_q <= mac_sum[32:16];
								job_q     <= JOB_SM_PEAK;
								mac_k_q   <= '0;
								mac_n_q   <= 3'd2;
								acc_q     <= '0;
							end
							JOB_SM_PEAK: begin
								peak_st_q <= mac_sum[32:16];
								state_q   <= ST_EMIT;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end

				ST_ROOT: begin
					if (root_ge) begin
						n_q   <= n_next;
						res_q <= res_take;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0])
						state_q <= ST_ACC;
				end

				ST_ACC: begin
					if (res_q[16:0] > peak_q)
						peak_q <= res_q[16:0];
					// saturate: hold sum and count, peak still tracks
					if (cnt_q < CNT_CAP) begin
						sum_q <= sum_q + SUM_W'(res_q[16:0]);
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end

				ST_NORM: begin
					if (norm_direct) begin
						if (norm_sel_q) begin
							lvl_peak_q <= norm_val;
							job_q      <= JOB_SM_MEAN;
							mac_k_q    <= '0;
							mac_n_q    <= 3'd2;
							acc_q      <= '0;
							state_q    <= ST_MAC;
						end else begin
							lvl_mean_q <= norm_val;
							norm_sel_q <= 1'b1;
						end
					end else begin
						rem_q      <= DV_W'(norm_v - level_low_q);
						dvd_q      <= '0;
						dvs_q      <= DV_W'(level_high_q - level_low_q);
						quo_q      <= '0;
						div_k_q    <= DK_W'(16);
						div_norm_q <= 1'b1;
						state_q    <= ST_DIV;
					end
				end

				ST_DIV: begin
					rem_q   <= rem_next;
					dvd_q   <= dvd_q << 1;
					quo_q   <= quo_next;
					div_k_q <= div_k_q - 1'b1;
					if (div_k_q == DK_W'(1)) begin
						if (!div_norm_q) begin
							raw_mean_q <= quo_next[16:0];
							norm_sel_q <= 1'b0;
							state_q    <= ST_NORM;
						end else if (norm_sel_q) begin
							lvl_peak_q <= quo_next[16:0];
							job_q      <= JOB_SM_MEAN;
							mac_k_q    <= '0;
							mac_n_q    <= 3'd2;
							acc_q      <= '0;
							state_q    <= ST_MAC;
						end else begin
							lvl_mean_q <= quo_next[16:0];
							norm_sel_q <= 1'b1;
							state_q    <= ST_NORM;
						end
					end
				end

				ST_EMIT: begin
					// wait for the output register to drain
					if (emit_fire) begin
						o_mean_q     <= mean_st_q;
						o_peak_q     <= peak_st_q;
						o_raw_mean_q <= raw_mean_q;
						o_raw_peak_q <= raw_peak_q;
						o_seen_q     <= seen_q;
						state_q      <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'd0, o_seen_q, o_raw_peak_q, o_raw_mean_q, o_peak_q, o_mean_q};

	`VMLT_ASSERT_ALWAYS(a_state_bound, (mean_st_q <= vmlt_pkg::ONE_Q16) && (peak_st_q <= vmlt_pkg::ONE_Q16), "smoothed state above one")
	`VMLT_ASSERT_IMPLY(a_root_range, state_q == ST_ACC, res_q <= 34'h10000, "root out of range")
	`VMLT_ASSERT_IMPLY(a_div_rem, state_q == ST_DIV, rem_q < dvs_q, "divider remainder not below divisor")
	`VMLT_ASSERT_NEXT(a_tick_clears, in_accept && (s_tuser == vmlt_pkg::OP_TICK), (cnt_q == '0) && (peak_q == '0) && (sum_q == '0), "tick left accumulators set")

endmodule
